// ===== rtl/slmb_pkg.sv =====
// Shared types and constants for the status LED mode blinker.
`default_nettype none

package slmb_pkg;

  // Width of every configuration register and of the blink counter.
  localparam int CFG_W = 16;
  localparam int COUNT_BITS_DEFAULT = 16;

  localparam logic [CFG_W-1:0] PERIOD_RESET   = 16'd1000;
  localparam logic [CFG_W-1:0] ON_RESET       = 16'd100;
  localparam logic [CFG_W-1:0] BLINK_RESET    = 16'd80;
  localparam logic [CFG_W-1:0] FEEDBACK_RESET = 16'd480;

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_CFG  = 2'd2,
    MODE_ERR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_INIT     = 3'd1,
    REQ_RUN      = 3'd2,
    REQ_WR_BEGIN = 3'd3,
    REQ_WR_END   = 3'd4,
    REQ_ERROR    = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    CFG_PERIOD   = 2'd0,
    CFG_ON       = 2'd1,
    CFG_BLINK    = 2'd2,
    CFG_FEEDBACK = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/slmb_rem.sv =====
// Bit-serial restoring remainder unit: dividend modulo a 16-bit divisor.
`default_nettype none

module slmb_rem
  import slmb_pkg::*;
#(
  parameter int DW = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DW-1:0]    dividend,
  input  wire logic [CFG_W-1:0] divisor,
  output logic                  done,
  output logic [CFG_W-1:0]      rem
);

  localparam int STEP_W = $clog2(DW + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DW-1:0]     dvd;
  logic [CFG_W-1:0]  dvs;
  logic [CFG_W-1:0]  part;
  logic [CFG_W:0]    shifted;
  logic [CFG_W-1:0]  part_next;

  // Bring down one dividend bit; subtract when the divisor fits.
  assign shifted = {part, dvd[DW-1]};
  always_comb begin
    if (shifted >= {1'b0, dvs}) begin
      part_next = CFG_W'(shifted - {1'b0, dvs});
    end else begin
      part_next = shifted[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      part <= '0;
    end else if (busy) begin
      dvd  <= dvd << 1;
      part <= part_next;
    end
  end

  assign rem = part;

endmodule

`default_nettype wire

// ===== rtl/status_led_mode_blinker.sv =====
// Status LED mode blinker: mode state machine, heartbeat and blink timing.
//
// Each accepted item is one event (a millisecond tick, init, set running,
// write begin, write end with a success bit, or set error) and yields one
// result: the LED level and the mode after that event. The state updates in
// the cycle an item is accepted and the result sits in an output register,
// so one item is taken per clock while the consumer keeps up. One exception:
// a running tick whose elapsed count reaches twice the period or more (only
// after the period register is lowered, or when running is entered dark
// with on_ms at or above the period) reduces the count through a bit-serial
// remainder unit, and no item is taken until its result appears. Registers
// are to be written via cfg_we/cfg_index/cfg_data only while the block is
// idle; the block itself does not enforce this.
`default_nettype none

module status_led_mode_blinker
  import slmb_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       req_type,
  input  wire logic             success,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  led_on,
  output logic [1:0]            mode,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int CW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [CW-1:0] CNT_MAX_W = CW'({COUNT_BITS{1'b1}});

  // Configuration registers
  logic [CFG_W-1:0] period_ms;
  logic [CFG_W-1:0] on_ms;
  logic [CFG_W-1:0] blink_half_ms;
  logic [CFG_W-1:0] feedback_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms     <= PERIOD_RESET;
      on_ms         <= ON_RESET;
      blink_half_ms <= BLINK_RESET;
      feedback_ms   <= FEEDBACK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PERIOD:   period_ms     <= cfg_data;
        CFG_ON:       on_ms         <= cfg_data;
        CFG_BLINK:    blink_half_ms <= cfg_data;
        CFG_FEEDBACK: feedback_ms   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // State
  mode_t                 mode_reg, mode_next;
  logic [COUNT_BITS-1:0] elapsed, elapsed_next;
  logic                  write_done, write_done_next;
  logic [CFG_W-1:0]      half_count, half_count_next;
  logic                  blink_dark, blink_dark_next;
  logic                  led_level, led_level_next;
  logic                  out_valid_next;
  logic                  rem_pending, rem_pending_next;

  logic             in_fire, out_fire;
  logic             rem_start, rem_done;
  logic [CFG_W-1:0] rem;
  logic             in_err;
  req_t             req;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = !rem_pending && (!out_valid || out_ready);
  assign in_err   = (mode_reg == MODE_ERR);
  assign req      = req_t'(req_type);

  // Tick arithmetic
  logic [COUNT_BITS-1:0] inc;
  logic [CW-1:0]         inc_w, per_w, on_w, fb_w, run_diff, run_new;
  logic [CFG_W-1:0]      per_eff, half_eff, half_inc;
  logic                  run_ge, run_long, fb_exit, half_wrap;
  logic [COUNT_BITS-1:0] on_sat;

  assign inc      = (elapsed == {COUNT_BITS{1'b1}}) ? elapsed : elapsed + 1'b1;
  assign inc_w    = CW'(inc);
  assign per_eff  = (period_ms == '0) ? CFG_W'(1) : period_ms;
  assign per_w    = CW'(per_eff);
  assign on_w     = CW'(on_ms);
  assign fb_w     = CW'(feedback_ms);
  assign run_ge   = (inc_w >= per_w);
  assign run_diff = inc_w - per_w;
  assign run_long = run_ge && (run_diff >= per_w);
  assign run_new  = run_ge ? run_diff : inc_w;
  assign fb_exit  = (mode_reg == MODE_CFG) && write_done && (inc_w >= fb_w);
  assign half_eff = (blink_half_ms == '0) ? CFG_W'(1) : blink_half_ms;
  assign half_inc = half_count + 1'b1;
  assign half_wrap = (half_inc >= half_eff);
  assign on_sat   = (on_w > CNT_MAX_W) ? CNT_MAX_W[COUNT_BITS-1:0] : on_w[COUNT_BITS-1:0];

  assign rem_start = in_fire && (req == REQ_TICK) && (mode_reg == MODE_RUN) && run_long;

  slmb_rem #(
    .DW (CW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (inc_w),
    .divisor  (per_eff),
    .done     (rem_done),
    .rem      (rem)
  );

  // Next mode and write-done flag
  always_comb begin
    mode_next       = mode_reg;
    write_done_next = write_done;
    if (in_fire) begin
      unique case (req)
        REQ_TICK: begin
          if (fb_exit) begin
            mode_next       = MODE_RUN;
            write_done_next = 1'b0;
          end
        end
        REQ_INIT: begin
          if (!in_err) begin
            mode_next       = MODE_INIT;
            write_done_next = 1'b0;
          end
        end
        REQ_RUN: begin
          if (!in_err) begin
            mode_next       = MODE_RUN;
            write_done_next = 1'b0;
          end
        end
        REQ_WR_BEGIN: begin
          if (!in_err) begin
            mode_next       = MODE_CFG;
            write_done_next = 1'b0;
          end
        end
        REQ_WR_END: begin
          if (!in_err) begin
            mode_next       = success ? MODE_CFG : MODE_ERR;
            write_done_next = success;
          end
        end
        REQ_ERROR: begin
          mode_next       = MODE_ERR;
          write_done_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Counters, LED level and output handshake
  always_comb begin
    elapsed_next     = elapsed;
    half_count_next  = half_count;
    blink_dark_next  = blink_dark;
    led_level_next   = led_level;
    out_valid_next   = out_valid && !out_fire;
    rem_pending_next = rem_pending;
    if (rem_done) begin
      elapsed_next     = COUNT_BITS'(rem);
      led_level_next   = (rem < on_ms);
      out_valid_next   = 1'b1;
      rem_pending_next = 1'b0;
    end
    if (in_fire) begin
      out_valid_next = !rem_start;
      unique case (req)
        REQ_TICK: begin
          elapsed_next = inc;
          unique case (mode_reg)
            MODE_INIT, MODE_ERR: led_level_next = 1'b1;
            MODE_RUN: begin
              if (run_long) begin
                // hold until the remainder unit returns the reduced count
                rem_pending_next = 1'b1;
              end else begin
                elapsed_next   = run_new[COUNT_BITS-1:0];
                led_level_next = (run_new < on_w);
              end
            end
            MODE_CFG: begin
              if (fb_exit) begin
                // enter running dark, as if the lit part already passed
                elapsed_next    = on_sat;
                half_count_next = '0;
                blink_dark_next = 1'b0;
                led_level_next  = 1'b0;
              end else if (half_wrap) begin
                half_count_next = '0;
                blink_dark_next = !blink_dark;
                led_level_next  = blink_dark;
              end else begin
                half_count_next = half_inc;
                led_level_next  = !blink_dark;
              end
            end
            default: ;
          endcase
        end
        REQ_INIT, REQ_RUN, REQ_WR_BEGIN: begin
          if (!in_err) begin
            elapsed_next    = '0;
            half_count_next = '0;
            blink_dark_next = 1'b0;
          end
          led_level_next = in_err ? led_level : 1'b1;
        end
        REQ_WR_END: begin
          if (!in_err) begin
            if (success) begin
              elapsed_next    = '0;
              half_count_next = '0;
              blink_dark_next = 1'b0;
            end
            led_level_next = 1'b1;
          end
        end
        REQ_ERROR: led_level_next = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= MODE_INIT;
      elapsed     <= '0;
      write_done  <= 1'b0;
      half_count  <= '0;
      blink_dark  <= 1'b0;
      led_level   <= 1'b1;
      out_valid   <= 1'b0;
      rem_pending <= 1'b0;
    end else begin
      mode_reg    <= mode_next;
      elapsed     <= elapsed_next;
      write_done  <= write_done_next;
      half_count  <= half_count_next;
      blink_dark  <= blink_dark_next;
      led_level   <= led_level_next;
      out_valid   <= out_valid_next;
      rem_pending <= rem_pending_next;
    end
  end

  assign led_on = led_level;
  assign mode   = mode_reg;

  // Checks
  a_err_latched: assert property (@(posedge clk) disable iff (rst)
    mode_reg == MODE_ERR |=> mode_reg == MODE_ERR)
    else $error("error mode left without reset");

  a_err_lit: assert property (@(posedge clk) disable iff (rst)
    mode_reg == MODE_ERR |-> led_level)
    else $error("LED dark in error mode");

  a_rem_blocks: assert property (@(posedge clk) disable iff (rst)
    rem_pending |-> !in_ready && !out_valid)
    else $error("item taken or result shown during remainder");

  a_rem_result: assert property (@(posedge clk) disable iff (rst)
    rem_done |=> out_valid && mode_reg == MODE_RUN)
    else $error("remainder finished without a running result");

endmodule

`default_nettype wire
